### hw/rtl/itra_pkg.sv
// shared widths, character constants and digit mapping for the radix converter
`default_nettype none

package itra_pkg;

  localparam int VALUE_BITS = 32;
  localparam int RADIX_BITS = 6;
  localparam int CHAR_BITS  = 8;

  // input word: number then radix, padded to whole bytes
  localparam int IN_BITS  = ((VALUE_BITS + RADIX_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = CHAR_BITS;

  // character store and counters
  localparam int BUF_DEPTH = VALUE_BITS;
  localparam int IDX_BITS  = $clog2(BUF_DEPTH);
  localparam int CNT_BITS  = $clog2(BUF_DEPTH + 1);
  localparam int BIT_BITS  = $clog2(VALUE_BITS);

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);
  localparam logic [RADIX_BITS-1:0] RADIX_DEC = RADIX_BITS'(10);

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;

  // digit value to lower-case ascii
  function automatic logic [CHAR_BITS-1:0] digit_code(input logic [RADIX_BITS-1:0] d);
    logic [CHAR_BITS-1:0] dx;
    dx = CHAR_BITS'(d);
    if (d < RADIX_DEC) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_A + (dx - CHAR_BITS'(RADIX_DEC));
  endfunction

endpackage

`default_nettype wire

### hw/rtl/integer_to_radix_ascii.sv
// integer to ascii digit string converter, any radix from 2 to 36
//
//  channel  | dir | tdata (lsb up)               | tlast          | tuser
//  in_      | in  | number[31:0], radix[37:32]   | -              | -
//  out_     | out | char_code[7:0]              | last character | bad_radix
//
// each digit costs one bit-serial division by the radix in the shared
// shift/subtract unit, followed by a store of the digit
// all digits are formed first, then each character is read out of the
// character store into a register and presented
// bad radix and zero skip the division and give one character of readout
// reset is synchronous, active low, and returns the sequencer to idle
// in_tready is low from the accepted word until the last character is taken;
// a stalled out_tready simply holds the presented character
`default_nettype none

module integer_to_radix_ascii (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [itra_pkg::IN_BITS-1:0] in_tdata,  // number, radix, zero pad
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [itra_pkg::OUT_BITS-1:0] out_tdata, // char_code
  output logic                         out_tlast,
  output logic                         out_tuser  // bad_radix
);
  import itra_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_DIGIT = 6'b000100,
    ST_SIGN  = 6'b001000,
    ST_FETCH = 6'b010000,
    ST_SHOW  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // working value: dividend shifts out the top, quotient bits shift in below
  logic [VALUE_BITS-1:0] num_r, num_nxt;
  logic [RADIX_BITS-1:0] radix_r, radix_nxt;
  logic [RADIX_BITS-1:0] rem_r, rem_nxt;
  logic [BIT_BITS-1:0]   bit_r, bit_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;   // characters stored so far
  logic [IDX_BITS-1:0]   rd_r, rd_nxt;     // readout pointer, counts down
  logic                  neg_r, neg_nxt;
  logic                  bad_r, bad_nxt;

  // character store, least significant character at entry 0
  logic [CHAR_BITS-1:0] buf_mem [BUF_DEPTH];
  logic [CHAR_BITS-1:0] rd_data_r;
  logic                 wr_en;
  logic [IDX_BITS-1:0]  wr_addr;
  logic [CHAR_BITS-1:0] wr_data;

  // input fields
  logic [VALUE_BITS-1:0] in_number;
  logic [RADIX_BITS-1:0] in_radix;
  logic                  in_bad;
  logic                  in_neg;

  // shared restoring divide step
  logic [RADIX_BITS:0] trial;
  logic                take;
  logic [RADIX_BITS:0] diff;

  assign in_number = in_tdata[VALUE_BITS-1:0];
  assign in_radix  = in_tdata[VALUE_BITS +: RADIX_BITS];
  assign in_bad    = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
  assign in_neg    = (in_radix == RADIX_DEC) && in_number[VALUE_BITS-1];

  assign trial = {rem_r, num_r[VALUE_BITS-1]};
  assign take  = trial >= {1'b0, radix_r};
  assign diff  = trial - {1'b0, radix_r};

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_SHOW);
  assign out_tdata  = rd_data_r;
  assign out_tlast  = (rd_r == '0);
  assign out_tuser  = bad_r;

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    radix_nxt = radix_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    cnt_nxt   = cnt_r;
    rd_nxt    = rd_r;
    neg_nxt   = neg_r;
    bad_nxt   = bad_r;
    wr_en     = 1'b0;
    wr_addr   = cnt_r[IDX_BITS-1:0];
    wr_data   = digit_code(rem_r);
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          radix_nxt = in_radix;
          neg_nxt   = in_neg;
          bad_nxt   = in_bad;
          rem_nxt   = '0;
          bit_nxt   = '0;
          rd_nxt    = '0;
          num_nxt   = in_neg ? ('0 - in_number) : in_number;
          priority if (in_bad) begin
            // one nul character flagged as an error
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = CHAR_NUL;
            cnt_nxt   = CNT_BITS'(1);
            state_nxt = ST_FETCH;
          end else if (in_number == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = CHAR_ZERO;
            cnt_nxt   = CNT_BITS'(1);
            state_nxt = ST_FETCH;
          end else begin
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = take ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
        num_nxt = {num_r[VALUE_BITS-2:0], take};
        bit_nxt = bit_r + BIT_BITS'(1);
        if (bit_r == BIT_BITS'(VALUE_BITS - 1)) begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        // remainder is the next digit, quotient stays in num_r
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + CNT_BITS'(1);
        rem_nxt = '0;
        bit_nxt = '0;
        priority if (num_r != '0) begin
          state_nxt = ST_DIV;
        end else if (neg_r) begin
          state_nxt = ST_SIGN;
        end else begin
          rd_nxt    = cnt_r[IDX_BITS-1:0];
          state_nxt = ST_FETCH;
        end
      end
      ST_SIGN: begin
        wr_en     = 1'b1;
        wr_data   = CHAR_MINUS;
        cnt_nxt   = cnt_r + CNT_BITS'(1);
        rd_nxt    = cnt_r[IDX_BITS-1:0];
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_tready) begin
          if (rd_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_nxt    = rd_r - IDX_BITS'(1);
            state_nxt = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rd_r    <= '0;
      bit_r   <= '0;
      neg_r   <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rd_r    <= rd_nxt;
      bit_r   <= bit_nxt;
      neg_r   <= neg_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    radix_r <= radix_nxt;
    rem_r   <= rem_nxt;
  end

  // character store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= wr_data;
    end
    if (state_r == ST_FETCH) begin
      rd_data_r <= buf_mem[rd_r];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/itra_checker.sv
// port-level checks for the radix converter and their bind
`default_nettype none

module itra_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           in_tvalid,
  input wire                           in_tready,
  input wire                           out_tvalid,
  input wire                           out_tready,
  input wire [itra_pkg::OUT_BITS-1:0]  out_tdata,
  input wire                           out_tlast,
  input wire                           out_tuser
);
  import itra_pkg::*;

  // no new word is taken while a character is on offer
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a character is presented");

  // an error word is a single nul character
  a_bad_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && out_tdata == CHAR_NUL))
    else $error("bad radix result is not a lone nul");

  // a freshly accepted word needs a store read before anything shows
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("character presented straight after accept");

  // stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled output changed");

endmodule

bind integer_to_radix_ascii itra_checker u_itra_checker (.*);

`default_nettype wire
